@@ hw/rtl/abt_pkg.sv @@
`default_nettype none

package abt_pkg;

	localparam int unsigned CfgW          = 13;
	localparam int unsigned AlphaW        = 8;
	localparam int unsigned PosW          = 12;
	localparam int unsigned SizeW         = 13;
	localparam int unsigned MaxDimDefault = 4096;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [AlphaW-1:0] pixel_alpha;
	} pixel_t;

	typedef struct packed {
		logic [PosW-1:0]  trim_left;
		logic [PosW-1:0]  trim_top;
		logic [SizeW-1:0] trim_width;
		logic [SizeW-1:0] trim_height;
	} trim_t;

	// one finished rectangle handed from the tracker to the output buffer
	typedef struct packed {
		logic  valid;
		trim_t trim;
	} trim_push_t;

endpackage

`default_nettype wire

@@ hw/rtl/abt_chan_if.sv @@
`default_nettype none

interface abt_pixel_if;
	logic            valid;
	logic            ready;
	abt_pkg::pixel_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface abt_trim_if;
	logic           valid;
	logic           ready;
	abt_pkg::trim_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/abt_core.sv @@
`default_nettype none

module abt_core #(
	parameter int unsigned MAX_DIM = abt_pkg::MaxDimDefault
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  abt_pkg::reg_index_t      cfg_index,
	input  logic [abt_pkg::CfgW-1:0] cfg_wdata,
	input  logic                     accept,
	input  abt_pkg::pixel_t          pixel,
	output abt_pkg::trim_push_t      push
);
	import abt_pkg::*;

	localparam int unsigned CW = $clog2(MAX_DIM);
	localparam int unsigned EW = (CfgW > CW + 1) ? CfgW : CW + 1;
	localparam logic [EW-1:0] MaxDimE = EW'(MAX_DIM);
	localparam logic [CW-1:0] MaxLast = CW'(MAX_DIM - 1);

	// last valid index for a size register: zero counts as one, large values saturate
	function automatic logic [CW-1:0] last_index(input logic [CfgW-1:0] v);
		logic [EW-1:0] ext;
		logic [EW-1:0] less;
		ext  = EW'(v);
		less = ext - EW'(1);
		if (v == '0) begin
			last_index = '0;
		end else if (ext > MaxDimE) begin
			last_index = MaxLast;
		end else begin
			last_index = less[CW-1:0];
		end
	endfunction

	logic [CfgW-1:0] width_q, height_q;
	logic [CW-1:0]   col_q, row_q;
	logic [CW-1:0]   min_col_q, max_col_q, min_row_q, max_row_q;
	logic            any_q;

	logic [CW-1:0]   last_col, last_row;
	logic            opaque, first, col_end, row_end, img_end, nxt_any;
	logic [CW-1:0]   nxt_min_col, nxt_max_col, nxt_min_row, nxt_max_row;
	logic [EW-1:0]   left_ext, top_ext, span_col, span_row;
	trim_t           result;

	always_comb begin
		last_col = last_index(width_q);
		last_row = last_index(height_q);
		opaque   = |pixel.pixel_alpha;
		first    = opaque & ~any_q;
		nxt_any  = any_q | opaque;
		col_end  = col_q >= last_col;
		row_end  = row_q >= last_row;
		img_end  = col_end & row_end;

		nxt_min_col = (first || (opaque && col_q < min_col_q)) ? col_q : min_col_q;
		nxt_max_col = (first || (opaque && col_q > max_col_q)) ? col_q : max_col_q;
		nxt_min_row = (first || (opaque && row_q < min_row_q)) ? row_q : min_row_q;
		nxt_max_row = (first || (opaque && row_q > max_row_q)) ? row_q : max_row_q;

		left_ext = EW'(nxt_min_col);
		top_ext  = EW'(nxt_min_row);
		span_col = EW'(nxt_max_col) - EW'(nxt_min_col) + EW'(1);
		span_row = EW'(nxt_max_row) - EW'(nxt_min_row) + EW'(1);

		if (nxt_any) begin
			result.trim_left   = left_ext[PosW-1:0];
			result.trim_top    = top_ext[PosW-1:0];
			result.trim_width  = span_col[SizeW-1:0];
			result.trim_height = span_row[SizeW-1:0];
		end else begin
			// nothing opaque: report a single pixel at the origin
			result.trim_left   = '0;
			result.trim_top    = '0;
			result.trim_width  = SizeW'(1);
			result.trim_height = SizeW'(1);
		end

		push.valid = accept & img_end;
		push.trim  = result;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CfgW'(1);
			height_q <= CfgW'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_wdata;
				REG_IMAGE_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			min_col_q <= '0;
			max_col_q <= '0;
			min_row_q <= '0;
			max_row_q <= '0;
			any_q     <= 1'b0;
		end else if (accept) begin
			if (img_end) begin
				col_q     <= '0;
				row_q     <= '0;
				min_col_q <= '0;
				max_col_q <= '0;
				min_row_q <= '0;
				max_row_q <= '0;
				any_q     <= 1'b0;
			end else begin
				col_q     <= col_end ? '0 : col_q + CW'(1);
				row_q     <= col_end ? row_q + CW'(1) : row_q;
				min_col_q <= nxt_min_col;
				max_col_q <= nxt_max_col;
				min_row_q <= nxt_min_row;
				max_row_q <= nxt_max_row;
				any_q     <= nxt_any;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/abt_out_buf.sv @@
`default_nettype none

module abt_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  abt_pkg::trim_push_t push,
	output logic                room,
	abt_trim_if.source          trim
);
	import abt_pkg::*;

	logic  head_v_q, skid_v_q;
	trim_t head_q, skid_q;
	logic  pop;

	assign pop        = head_v_q & trim.ready;
	assign room       = ~skid_v_q;
	assign trim.valid = head_v_q;
	assign trim.data  = head_q;

	// a push only arrives while the skid slot is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			head_v_q <= skid_v_q | push.valid;
			skid_v_q <= 1'b0;
		end else if (push.valid) begin
			head_v_q <= 1'b1;
			skid_v_q <= head_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_v_q) begin
			head_q <= skid_q;
		end else if (push.valid && (pop || !head_v_q)) begin
			head_q <= push.trim;
		end
		if (push.valid && head_v_q && !pop) begin
			skid_q <= push.trim;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/alpha_bounding_box_trim.sv @@
// Channel  Dir  Transfer             Payload
// pix      in   pix.valid&pix.ready  pixel_alpha, raster order
// trim     out  trim.valid&trim.ready trim_left, trim_top, trim_width, trim_height
//
// One pixel per clock while pix.ready is high; the bound compares and counter
// steps sit between the accepted pixel and the tracker registers, the rectangle
// lands in a two-entry output buffer in the cycle after the image's last pixel.
// pix.ready drops only while both output entries are full.
// arst_n clears counters, bounds and buffer; sizes reset to 1x1.
`default_nettype none

module alpha_bounding_box_trim #(
	parameter int unsigned MAX_DIM = abt_pkg::MaxDimDefault
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  abt_pkg::reg_index_t      cfg_index,
	input  logic [abt_pkg::CfgW-1:0] cfg_wdata,
	abt_pixel_if.sink                pix,
	abt_trim_if.source               trim
);
	import abt_pkg::*;

	trim_push_t push;
	logic       room;
	logic       accept;

	assign pix.ready = room;
	assign accept    = pix.valid & room;

	abt_core #(
		.MAX_DIM(MAX_DIM)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.accept   (accept),
		.pixel    (pix.data),
		.push     (push)
	);

	abt_out_buf u_out_buf (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.room  (room),
		.trim  (trim)
	);

`ifndef SYNTHESIS
	a_push_on_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (pix.valid && pix.ready))
		else $error("rectangle pushed without a pixel transfer");

	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pix.ready |-> trim.valid)
		else $error("input stalled with an empty output");

	a_stall_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(pix.ready) |-> $past(push.valid))
		else $error("input stall without a new rectangle");
`endif

endmodule

`default_nettype wire

@@ sim/tb_alpha_bounding_box_trim.sv @@
module tb_alpha_bounding_box_trim;
	timeunit 1ns;
	timeprecision 1ps;

	import abt_pkg::*;

	localparam int unsigned STALL_LIMIT     = 4000;
	localparam int unsigned DRAIN_CYCLES    = 8;
	localparam int unsigned NUM_PHASES      = 4;
	localparam int unsigned ITEMS_PER_PHASE = 320;
	localparam int unsigned NUM_STEPS       = 30;

	typedef enum logic [1:0] {
		FILL_EMPTY,
		FILL_RECT,
		FILL_SPARSE,
		FILL_NOISE
	} fill_t;

	// one row of the directed table: either a register write or one pixel
	typedef struct packed {
		logic              is_cfg;
		reg_index_t        idx;
		logic [CfgW-1:0]   value;
		logic [AlphaW-1:0] alpha;
		logic              typed;
		trim_t             want;
	} step_row_t;

	bit                clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	reg_index_t        cfg_index;
	logic [CfgW-1:0]   cfg_wdata;

	abt_pixel_if pix_ch();
	abt_trim_if  trim_ch();

	alpha_bounding_box_trim dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pix       (pix_ch),
		.trim      (trim_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the tracker
	logic [CfgW-1:0] width_reg;
	logic [CfgW-1:0] height_reg;
	int unsigned     col_pos, row_pos;
	int unsigned     lo_col, hi_col, lo_row, hi_row;
	bit              seen_opaque;

	trim_t           trims_due[$];

	int unsigned src_idle     = 0;
	int unsigned sink_stall   = 0;
	int unsigned mismatches   = 0;
	int unsigned pixels_sent  = 0;
	int unsigned rects_seen   = 0;
	int unsigned cfg_writes   = 0;
	int unsigned images_done  = 0;
	int unsigned stall_cycles = 0;

	function automatic int unsigned clamp_dim(logic [CfgW-1:0] v);
		if (v == 0)
			return 1;
		if (v > MaxDimDefault)
			return MaxDimDefault;
		return v;
	endfunction

	function automatic void forget_image();
		col_pos     = 0;
		row_pos     = 0;
		lo_col      = 0;
		hi_col      = 0;
		lo_row      = 0;
		hi_row      = 0;
		seen_opaque = 1'b0;
	endfunction

	// advance the shadow by one pixel; returns 1 when the image closes
	function automatic bit track_pixel(input logic [AlphaW-1:0] a, output trim_t r);
		int unsigned w, h;
		w = clamp_dim(width_reg);
		h = clamp_dim(height_reg);
		r = '0;
		if (a != 0) begin
			if (!seen_opaque) begin
				lo_row      = row_pos;
				hi_row      = row_pos;
				lo_col      = col_pos;
				hi_col      = col_pos;
				seen_opaque = 1'b1;
			end else begin
				if (row_pos < lo_row) lo_row = row_pos;
				if (row_pos > hi_row) hi_row = row_pos;
				if (col_pos < lo_col) lo_col = col_pos;
				if (col_pos > hi_col) hi_col = col_pos;
			end
		end
		if (col_pos < w - 1) begin
			col_pos++;
			return 1'b0;
		end
		col_pos = 0;
		if (row_pos < h - 1) begin
			row_pos++;
			return 1'b0;
		end
		if (seen_opaque) begin
			r.trim_left   = PosW'(lo_col);
			r.trim_top    = PosW'(lo_row);
			r.trim_width  = SizeW'(hi_col - lo_col + 1);
			r.trim_height = SizeW'(hi_row - lo_row + 1);
		end else begin
			r.trim_width  = SizeW'(1);
			r.trim_height = SizeW'(1);
		end
		forget_image();
		return 1'b1;
	endfunction

	function automatic logic [CfgW-1:0] pick_dim();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		if (r < 12)
			return CfgW'($urandom_range(40, 9));
		return CfgW'($urandom_range(8, 1));
	endfunction

	function automatic step_row_t px(logic [AlphaW-1:0] a);
		step_row_t s;
		s       = '0;
		s.alpha = a;
		return s;
	endfunction

	function automatic step_row_t px_trim(logic [AlphaW-1:0] a, int unsigned l, int unsigned t,
			int unsigned w, int unsigned h);
		step_row_t s;
		s                  = '0;
		s.alpha            = a;
		s.typed            = 1'b1;
		s.want.trim_left   = PosW'(l);
		s.want.trim_top    = PosW'(t);
		s.want.trim_width  = SizeW'(w);
		s.want.trim_height = SizeW'(h);
		return s;
	endfunction

	function automatic step_row_t cfg_row(reg_index_t idx, int unsigned v);
		step_row_t s;
		s        = '0;
		s.is_cfg = 1'b1;
		s.idx    = idx;
		s.value  = CfgW'(v);
		return s;
	endfunction

	task automatic send_pixel(input logic [AlphaW-1:0] a, input bit typed, input trim_t want);
		trim_t r;
		while ($urandom_range(99) < src_idle) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid            <= 1'b1;
		pix_ch.data.pixel_alpha <= a;
		do
			@(posedge clk);
		while (pix_ch.ready !== 1'b1);
		pixels_sent++;
		if (track_pixel(a, r))
			trims_due.push_back(typed ? want : r);
	endtask

	// hold the pixel side until every rectangle is out and the pipe is quiet
	task automatic settle();
		pix_ch.valid <= 1'b0;
		while (trims_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [CfgW-1:0] v);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		if (idx == REG_IMAGE_WIDTH)
			width_reg = v;
		else
			height_reg = v;
		cfg_writes++;
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		trim_t want;
		if (arst_n && trim_ch.valid === 1'b1 && trim_ch.ready === 1'b1) begin
			rects_seen++;
			if (trims_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: rectangle with none pending: l=%0d t=%0d w=%0d h=%0d", $realtime,
						trim_ch.data.trim_left, trim_ch.data.trim_top,
						trim_ch.data.trim_width, trim_ch.data.trim_height);
			end else begin
				want = trims_due.pop_front();
				if (trim_ch.data.trim_left !== want.trim_left ||
						trim_ch.data.trim_top !== want.trim_top ||
						trim_ch.data.trim_width !== want.trim_width ||
						trim_ch.data.trim_height !== want.trim_height) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: rect %0d want l=%0d t=%0d w=%0d h=%0d got l=%0d t=%0d w=%0d h=%0d",
							$realtime, rects_seen, want.trim_left, want.trim_top, want.trim_width,
							want.trim_height, trim_ch.data.trim_left, trim_ch.data.trim_top,
							trim_ch.data.trim_width, trim_ch.data.trim_height);
				end
			end
		end
		trim_ch.ready <= ($urandom_range(99) >= sink_stall);
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) ||
				(trim_ch.valid === 1'b1 && trim_ch.ready === 1'b1))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d rectangles pending",
				STALL_LIMIT, trims_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		step_row_t         steps [0:NUM_STEPS-1];
		int unsigned       k, ew, eh, rl, rr, rt, rb, sent, mid_cut, phase_items;
		logic [AlphaW-1:0] a, nz;
		logic [CfgW-1:0]   nw, nh;
		fill_t             style;

		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_IMAGE_WIDTH;
		cfg_wdata     = '0;
		pix_ch.valid  = 1'b0;
		pix_ch.data   = '0;
		trim_ch.ready = 1'b0;
		width_reg     = 1;
		height_reg    = 1;
		forget_image();

		steps = '{
			// 1x1 after reset: empty and opaque both give the unit box
			px_trim(8'd0, 0, 0, 1, 1),
			px_trim(8'd255, 0, 0, 1, 1),
			px_trim(8'd1, 0, 0, 1, 1),
			cfg_row(REG_IMAGE_WIDTH, 3),
			cfg_row(REG_IMAGE_HEIGHT, 2),
			px(8'd0), px(8'd0), px(8'd128), px(8'd0), px(8'd0),
			px_trim(8'd0, 2, 0, 1, 1),
			// zero width acts as one column
			cfg_row(REG_IMAGE_WIDTH, 0),
			px(8'd0),
			px_trim(8'd7, 0, 1, 1, 1),
			// width shrinks under a column counter already past it
			cfg_row(REG_IMAGE_WIDTH, 4),
			cfg_row(REG_IMAGE_HEIGHT, 3),
			px(8'd0), px(8'd0), px(8'd5),
			cfg_row(REG_IMAGE_WIDTH, 2),
			px(8'd128), px(8'd0), px(8'd0), px(8'd16), px(8'd0),
			// height shrinks under the row counter: image closes at row end
			px(8'd0), px(8'd0), px(8'd2),
			cfg_row(REG_IMAGE_HEIGHT, 1),
			px(8'd0)
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i]) begin
			if (steps[i].is_cfg)
				write_reg(steps[i].idx, steps[i].value);
			else
				send_pixel(steps[i].alpha, steps[i].typed, steps[i].want);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin src_idle = 0;  sink_stall = 0;  end
				1: begin src_idle = 78; sink_stall = 0;  end
				2: begin src_idle = 0;  sink_stall = 78; end
				default: begin src_idle = 13; sink_stall = 13; end
			endcase

			// full-size row, saturated row, saturated column: a few pixels, then 1x1 closes it
			if (p == 0) begin
				for (int b = 0; b < 3; b++) begin
					write_reg(REG_IMAGE_WIDTH, (b == 2) ? CfgW'(1) : ((b == 0) ? CfgW'(4096) : '1));
					write_reg(REG_IMAGE_HEIGHT, (b == 2) ? '1 : CfgW'(1));
					for (k = 0; k < 6; k++) begin
						a = (k == 0 || $urandom_range(2) == 0) ?
							AlphaW'($urandom_range(255, 1)) : '0;
						send_pixel(a, 1'b0, '0);
					end
					write_reg(REG_IMAGE_WIDTH, CfgW'(1));
					write_reg(REG_IMAGE_HEIGHT, CfgW'(1));
					do
						send_pixel(AlphaW'($urandom_range(255)), 1'b0, '0);
					while (col_pos != 0 || row_pos != 0);
					images_done++;
				end
			end

			phase_items = 0;
			while (phase_items < ITEMS_PER_PHASE) begin
				if (phase_items == 0 || $urandom_range(99) < 30) begin
					nw = pick_dim();
					nh = pick_dim();
					if (nw > 9 && nh > 3)
						nh = CfgW'($urandom_range(3, 1));
					write_reg(REG_IMAGE_WIDTH, nw);
					write_reg(REG_IMAGE_HEIGHT, nh);
				end else if ($urandom_range(99) < 5) begin
					settle();
				end
				ew      = clamp_dim(width_reg);
				eh      = clamp_dim(height_reg);
				style   = fill_t'($urandom_range(3));
				rl      = $urandom_range(ew - 1);
				rr      = $urandom_range(ew - 1, rl);
				rt      = $urandom_range(eh - 1);
				rb      = $urandom_range(eh - 1, rt);
				mid_cut = ($urandom_range(99) < 8) ? $urandom_range(ew * eh, 1) : 0;
				sent    = 0;
				do begin
					nz = AlphaW'($urandom_range(255, 1));
					case (style)
						FILL_EMPTY:  a = '0;
						FILL_RECT:   a = (col_pos >= rl && col_pos <= rr && row_pos >= rt &&
							row_pos <= rb && $urandom_range(9) < 7) ? nz : '0;
						FILL_SPARSE: a = ($urandom_range(9) == 0) ? nz : '0;
						default:     a = ($urandom_range(1) == 1) ? AlphaW'($urandom_range(255)) : '0;
					endcase
					send_pixel(a, 1'b0, '0);
					sent++;
					phase_items++;
					if (sent == mid_cut && (col_pos != 0 || row_pos != 0)) begin
						write_reg(REG_IMAGE_WIDTH, pick_dim());
						write_reg(REG_IMAGE_HEIGHT, CfgW'($urandom_range(4)));
					end
				end while (col_pos != 0 || row_pos != 0);
				images_done++;
			end
		end

		pix_ch.valid <= 1'b0;
		while (trims_due.size() != 0)
			@(posedge clk);
		repeat (2 * DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d pixels in %0d images and %0d size writes over %0d idle patterns",
			pixels_sent, images_done, cfg_writes, NUM_PHASES);
		$display("%0d rectangles compared, %0d mismatches", rects_seen, mismatches);
		if (mismatches == 0 && trims_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/abt_pkg.sv
hw/rtl/abt_chan_if.sv
hw/rtl/abt_core.sv
hw/rtl/abt_out_buf.sv
hw/rtl/alpha_bounding_box_trim.sv
sim/tb_alpha_bounding_box_trim.sv
